@@ rtl/pat_pkg.sv @@
// Package with the codes, types and CRC helper for the PAT section parser.
package pat_pkg;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_UNCHANGED = 3'd1,
    STATUS_HELD      = 3'd2,
    STATUS_TABLE_ID  = 3'd3,
    STATUS_FIXED     = 3'd4,
    STATUS_LENGTH    = 3'd5,
    STATUS_CRC       = 3'd6
  } status_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_ENTRY  = 1'b1
  } kind_e;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  // Entry word: program number in the upper 16 bits, PID in the lower 13.
  typedef logic [28:0] entry_t;

  localparam logic [7:0]  TableIdPat   = 8'h00;
  localparam logic [7:0]  FixedMask    = 8'hCC;
  localparam logic [7:0]  FixedValue   = 8'h80;
  localparam logic [31:0] CrcPoly      = 32'h04C11DB7;
  localparam logic [31:0] CrcInit      = 32'hFFFFFFFF;
  localparam logic [10:0] CountSat     = 11'h7FF;

  // MPEG-2 CRC32 over one byte, MSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'h000000};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/pat_section_parser.sv @@
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle unless the output stalls; the entry table is one memory
// with one write port and one registered read port, and the CRC takes one byte per cycle.
// Only a section's last byte and read requests produce a result word.
// Reset (asynchronous, active low) clears the section state and the committed count, sets
// the committed header to zero with its current/next flag set; the table is not cleared.
module pat_section_parser #(
  parameter int MAX_ENTRIES       = 256,
  parameter int MAX_SECTION_BYTES = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   action_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   last_i,
  input  logic [7:0]             entry_index_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   kind_o,
  output logic [2:0]             status_o,
  output logic [15:0]            ts_id_o,
  output logic [4:0]             version_o,
  output logic                   cur_nxt_o,
  output logic [8:0]             entry_count_o,
  output logic [15:0]            program_number_o,
  output logic [12:0]            map_pid_o,
  output logic                   entry_valid_o
);
  import pat_pkg::*;

  localparam int          IdxW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [8:0]  MaxEnt   = 9'(MAX_ENTRIES);
  localparam logic [10:0] MaxBytes = 11'(MAX_SECTION_BYTES);

  // Section state.
  logic [31:0] crc_q, crc_d;
  logic [31:0] tail_q, tail_d;
  logic [10:0] count_q, count_d;
  logic [1:0]  checks_q, checks_d;
  logic [21:0] phdr_q, phdr_d;
  logic [23:0] asm_q, asm_d;
  logic [8:0]  pcount_q, pcount_d;

  // Committed state.
  logic [8:0]  ccount_q, ccount_d;
  logic [31:0] scrc_q, scrc_d;
  logic [21:0] chdr_q, chdr_d;

  // Entry table.
  entry_t      mem [MAX_ENTRIES];
  entry_t      rd_data_q;
  logic        wr_en;
  logic [IdxW-1:0] wr_addr;
  entry_t      wr_data;
  logic        rd_en;

  // Output register.
  logic        out_valid_q;
  kind_e       kind_q;
  status_e     status_q, status_c;
  logic [21:0] ohdr_q;
  logic [8:0]  ocount_q;
  logic        evalid_q;

  logic        accept;
  logic        is_byte;
  logic        is_read;
  logic        idx_ok;
  logic [10:0] cnt_base;
  logic [8:0]  cnt_c;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_byte    = accept && (action_i == ACT_BYTE);
  assign is_read    = accept && (action_i == ACT_READ);
  assign idx_ok     = ({1'b0, entry_index_i} < ccount_q) && ({1'b0, entry_index_i} < MaxEnt);
  assign rd_en      = is_read && idx_ok;

  always_comb begin
    crc_d    = crc_q;
    tail_d   = tail_q;
    count_d  = count_q;
    checks_d = checks_q;
    phdr_d   = phdr_q;
    asm_d    = asm_q;
    pcount_d = pcount_q;
    ccount_d = ccount_q;
    scrc_d   = scrc_q;
    chdr_d   = chdr_q;
    wr_en    = 1'b0;
    wr_addr  = pcount_q[IdxW-1:0];
    wr_data  = {asm_q[23:8], asm_q[4:0], data_byte_i};
    status_c = STATUS_OK;
    cnt_base = 11'd0;
    cnt_c    = 9'd0;

    if (is_byte) begin
      // The CRC trails the input by four bytes so the received CRC stays out of it.
      if (count_q >= 11'd4) begin
        crc_d = crc_byte(crc_q, tail_q[31:24]);
      end
      tail_d = {tail_q[23:0], data_byte_i};

      if (count_q == 11'd0 && data_byte_i == TableIdPat) begin
        checks_d[0] = 1'b1;
      end
      if (count_q == 11'd1 && (data_byte_i & FixedMask) == FixedValue) begin
        checks_d[1] = 1'b1;
      end
      if (count_q == 11'd3) begin
        phdr_d[21:14] = data_byte_i;
      end
      if (count_q == 11'd4) begin
        phdr_d[13:6] = data_byte_i;
      end
      if (count_q == 11'd5) begin
        phdr_d[5:0] = data_byte_i[5:0];
      end
      if (count_q >= 11'd8 && count_q < MaxBytes) begin
        if (count_q[1:0] != 2'd3) begin
          asm_d = {asm_q[15:0], data_byte_i};
        end else begin
          if (pcount_q < MaxEnt) begin
            wr_en    = (ccount_q == 9'd0);
            pcount_d = pcount_q + 9'd1;
          end
          asm_d = 24'd0;
        end
      end
      if (count_q != CountSat) begin
        count_d = count_q + 11'd1;
      end

      if (last_i) begin
        if (tail_d == scrc_q) begin
          status_c = STATUS_UNCHANGED;
        end else if (!checks_d[0]) begin
          status_c = STATUS_TABLE_ID;
        end else if (!checks_d[1]) begin
          status_c = STATUS_FIXED;
        end else if (count_d > MaxBytes) begin
          status_c = STATUS_LENGTH;
        end else if (crc_d != tail_d) begin
          status_c = STATUS_CRC;
        end else if (ccount_q != 9'd0) begin
          status_c = STATUS_HELD;
        end else begin
          status_c = STATUS_OK;
        end

        // Entry count from the length: groups starting before the last four bytes.
        if (count_d > 11'd12) begin
          cnt_base = (count_d - 11'd9) >> 2;
        end
        cnt_c = (9'(cnt_base) > pcount_d) ? pcount_d : 9'(cnt_base);

        if (status_c == STATUS_OK) begin
          ccount_d = cnt_c;
          scrc_d   = tail_d;
          chdr_d   = phdr_d;
        end

        crc_d    = CrcInit;
        tail_d   = 32'd0;
        count_d  = 11'd0;
        checks_d = 2'd0;
        phdr_d   = 22'd0;
        asm_d    = 24'd0;
        pcount_d = 9'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcInit;
      tail_q      <= 32'd0;
      count_q     <= 11'd0;
      checks_q    <= 2'd0;
      phdr_q      <= 22'd0;
      asm_q       <= 24'd0;
      pcount_q    <= 9'd0;
      ccount_q    <= 9'd0;
      scrc_q      <= 32'd0;
      chdr_q      <= 22'd1;
      out_valid_q <= 1'b0;
    end else begin
      crc_q    <= crc_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      checks_q <= checks_d;
      phdr_q   <= phdr_d;
      asm_q    <= asm_d;
      pcount_q <= pcount_d;
      ccount_q <= ccount_d;
      scrc_q   <= scrc_d;
      chdr_q   <= chdr_d;
      if (accept) begin
        out_valid_q <= is_read || last_i;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; the header and count are taken after this word's commit.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= is_read ? KIND_ENTRY : KIND_STATUS;
      status_q <= is_read ? STATUS_OK : status_c;
      ohdr_q   <= chdr_d;
      ocount_q <= ccount_d;
      evalid_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[entry_index_i[IdxW-1:0]];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign status_o         = status_q;
  assign ts_id_o          = ohdr_q[21:6];
  assign version_o        = ohdr_q[5:1];
  assign cur_nxt_o        = ohdr_q[0];
  assign entry_count_o    = ocount_q;
  assign entry_valid_o    = evalid_q;
  assign program_number_o = evalid_q ? rd_data_q[28:13] : 16'd0;
  assign map_pid_o        = evalid_q ? rd_data_q[12:0] : 13'd0;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ccount_q <= MaxEnt)
    else $error("committed entry count exceeds table depth");

  a_status_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_STATUS) |-> (!entry_valid_o && program_number_o == 16'd0))
    else $error("status word carries entry data");

  a_read_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_read |=> (out_valid_o && kind_o == KIND_ENTRY))
    else $error("read request produced no entry word");

  a_stall_no_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(ccount_q) && $stable(chdr_q)))
    else $error("committed state changed while a word was stalled");
`endif

endmodule
